/* rtl/stepper_pulse_gen_ramped_macros.svh */
// ----------------------------------------------------------------------------
// stepper_pulse_gen_ramped_macros
// Assertion helpers for the step/direction generator.
// ----------------------------------------------------------------------------
`ifndef STEPPER_PULSE_GEN_RAMPED_MACROS_SVH
`define STEPPER_PULSE_GEN_RAMPED_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spg_pkg.sv */
// ----------------------------------------------------------------------------
// spg_pkg
// Shared widths, constants and divider handshake types for the step generator.
// ----------------------------------------------------------------------------
package spg_pkg;

  // field and register widths
  localparam int IntvW  = 19;
  localparam int CfgW   = 16;
  localparam int SpeedW = 13;
  localparam int MagW   = 12;
  localparam int AddrW  = 3;

  // step period numerator: 60 s * 1e6 us / (200 steps * 16 usteps) * 16
  localparam logic [IntvW-1:0] StepDividend = 19'd300000;
  localparam int               DivSteps     = IntvW;

  // register indexes
  localparam logic [AddrW-1:0] CfgMinInterval = 3'd0;
  localparam logic [AddrW-1:0] CfgPulseWidth  = 3'd1;
  localparam logic [AddrW-1:0] CfgDirSetup    = 3'd2;
  localparam logic [AddrW-1:0] CfgIdlePeriod  = 3'd3;
  localparam logic [AddrW-1:0] CfgMaxSpeed    = 3'd4;

  // register reset values
  localparam logic [CfgW-1:0]  RstMinInterval = 16'd1800;
  localparam logic [CfgW-1:0]  RstPulseWidth  = 16'd80;
  localparam logic [CfgW-1:0]  RstDirSetup    = 16'd120;
  localparam logic [CfgW-1:0]  RstIdlePeriod  = 16'd1000;
  localparam logic [MagW-1:0]  RstMaxSpeed    = 12'd1280;
  localparam logic [IntvW-1:0] RstInterval    = 19'd1000;

  // divider request and response
  typedef struct packed {
    logic            start;
    logic [MagW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IntvW-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/spg_div.sv */
// ----------------------------------------------------------------------------
// spg_div
// Restoring divider: constant step dividend over a 12-bit speed, one bit/cycle.
// ----------------------------------------------------------------------------
module spg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spg_pkg::div_req_t req_i,
  output spg_pkg::div_rsp_t rsp_o
);
  import spg_pkg::*;

  localparam int CntW = $clog2(DivSteps);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [MagW-1:0]  dvsr_q, dvsr_d;
  logic [MagW-1:0]  rem_q, rem_d;
  logic [IntvW-1:0] quo_q, quo_d;
  logic [MagW:0]    trial;
  logic [MagW:0]    diff;
  logic             ge;

  // one shared subtract/compare per cycle
  assign trial = {rem_q, quo_q[IntvW-1]};
  assign diff  = trial - {1'b0, dvsr_q};
  assign ge    = trial >= {1'b0, dvsr_q};

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvsr_d = dvsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvsr_d = req_i.divisor;
      rem_d  = '0;
      quo_d  = StepDividend;
    end else if (busy_q) begin
      rem_d = ge ? diff[MagW-1:0] : trial[MagW-1:0];
      quo_d = {quo_q[IntvW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvsr_q <= dvsr_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

/* rtl/stepper_pulse_gen_ramped.sv */
// ----------------------------------------------------------------------------
// stepper_pulse_gen_ramped
// Step/direction pulse generator with a one-microsecond-per-step speed ramp.
// ----------------------------------------------------------------------------
// Alarm: StExec, then StLow if it ends a step pulse, then StEmit; stop: StExec,
// then StEmit. A nonzero speed command gives no result and holds the block in
// StDiv until the 19-step divider is done. Input is taken again after the result
// moves to the output register, so no new item is taken before the last is done.
// Reset (async, active low) loads register defaults, stops the motor and
// empties the output register.
// ----------------------------------------------------------------------------
`include "stepper_pulse_gen_ramped_macros.svh"

module stepper_pulse_gen_ramped (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [spg_pkg::AddrW-1:0]    cfg_addr_i,
  input  logic [spg_pkg::CfgW-1:0]     cfg_wdata_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // [12:0] speed_cmd, [15:13] zero
  input  logic                         s_axis_tuser,   // [0] kind
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata    // [0] step_level, [1] dir_level,
                                                       // [20:2] next_delay_us, [23:21] zero
);
  import spg_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StLow  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  // configuration registers
  logic [CfgW-1:0] min_q, pw_q, setup_q, idle_q;
  logic [MagW-1:0] maxspd_q;

  // control state
  logic [2:0]       state_q, state_d;
  logic             running_q, running_d;
  logic             pulse_q, pulse_d;
  logic             cw_q, cw_d;
  logic             gap_q, gap_d;
  logic             dpin_q, dpin_d;
  logic [IntvW-1:0] cur_q, cur_d;
  logic [IntvW-1:0] tgt_q, tgt_d;
  logic             m_valid_q, m_valid_d;

  // item and result holding
  logic              kind_q;
  logic [SpeedW-1:0] speed_q;
  logic              res_step_q, res_step_d;
  logic              res_dir_q, res_dir_d;
  logic [IntvW-1:0]  res_dly_q, res_dly_d;
  logic [23:0]       m_data_q, m_data_d;

  // command decode
  logic              cmd_cw;
  logic [SpeedW-1:0] mag_raw;
  logic [MagW-1:0]   mag;
  logic [IntvW-1:0]  min_ext, pw_ext;
  logic [IntvW-1:0]  cur_step;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign min_ext = {{(IntvW-CfgW){1'b0}}, min_q};
  assign pw_ext  = {{(IntvW-CfgW){1'b0}}, pw_q};

  // magnitude of the command, clamped to 1..max_speed
  assign cmd_cw  = ~speed_q[SpeedW-1];
  assign mag_raw = cmd_cw ? speed_q : (~speed_q + 1'b1);
  always_comb begin
    if (mag_raw > {1'b0, maxspd_q}) begin
      mag = maxspd_q;
    end else begin
      mag = mag_raw[MagW-1:0];
    end
    if (mag == '0) begin
      mag = MagW'(1);
    end
  end

  // one-microsecond ramp toward target
  assign cur_step = (cur_q < tgt_q) ? cur_q + 1'b1 : cur_q - 1'b1;

  assign div_req.start   = (state_q == StExec) && kind_q && (speed_q != '0);
  assign div_req.divisor = mag;

  spg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    running_d  = running_q;
    pulse_d    = pulse_q;
    cw_d       = cw_q;
    gap_d      = gap_q;
    dpin_d     = dpin_q;
    cur_d      = cur_q;
    tgt_d      = tgt_q;
    res_step_d = res_step_q;
    res_dir_d  = res_dir_q;
    res_dly_d  = res_dly_q;
    m_valid_d  = m_valid_q & ~m_axis_tready;
    m_data_d   = m_data_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (!kind_q) begin
          if (!running_q) begin
            res_step_d = 1'b0;
            res_dir_d  = dpin_q;
            res_dly_d  = {{(IntvW-CfgW){1'b0}}, idle_q};
            state_d    = StEmit;
          end else if (!pulse_q) begin
            dpin_d    = cw_q;
            res_dir_d = cw_q;
            if (gap_q) begin
              gap_d      = 1'b0;
              res_step_d = 1'b0;
              res_dly_d  = {{(IntvW-CfgW){1'b0}}, setup_q};
            end else begin
              pulse_d    = 1'b1;
              res_step_d = 1'b1;
              res_dly_d  = pw_ext;
            end
            state_d = StEmit;
          end else begin
            pulse_d = 1'b0;
            if (cur_q != tgt_q) begin
              cur_d = (cur_step < min_ext) ? min_ext : cur_step;
            end
            state_d = StLow;
          end
        end else if (speed_q == '0) begin
          // stop command
          running_d  = 1'b0;
          pulse_d    = 1'b0;
          cur_d      = {{(IntvW-CfgW){1'b0}}, idle_q};
          tgt_d      = {{(IntvW-CfgW){1'b0}}, idle_q};
          res_step_d = 1'b0;
          res_dir_d  = dpin_q;
          res_dly_d  = {{(IntvW-CfgW){1'b0}}, idle_q};
          state_d    = StEmit;
        end else begin
          if (cw_q != cmd_cw) begin
            cw_d  = cmd_cw;
            gap_d = 1'b1;
          end
          state_d = StDiv;
        end
      end
      StLow: begin
        res_step_d = 1'b0;
        res_dir_d  = dpin_q;
        res_dly_d  = (cur_q > pw_ext) ? cur_q - pw_ext : min_ext;
        state_d    = StEmit;
      end
      StDiv: begin
        if (div_rsp.done) begin
          tgt_d     = (div_rsp.quot < min_ext) ? min_ext : div_rsp.quot;
          running_d = 1'b1;
          state_d   = StIdle;
        end
      end
      StEmit: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'b000, res_dly_q, res_dir_q, res_step_q};
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      running_q <= 1'b0;
      pulse_q   <= 1'b0;
      cw_q      <= 1'b1;
      gap_q     <= 1'b0;
      dpin_q    <= 1'b0;
      cur_q     <= RstInterval;
      tgt_q     <= RstInterval;
      m_valid_q <= 1'b0;
      min_q     <= RstMinInterval;
      pw_q      <= RstPulseWidth;
      setup_q   <= RstDirSetup;
      idle_q    <= RstIdlePeriod;
      maxspd_q  <= RstMaxSpeed;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      pulse_q   <= pulse_d;
      cw_q      <= cw_d;
      gap_q     <= gap_d;
      dpin_q    <= dpin_d;
      cur_q     <= cur_d;
      tgt_q     <= tgt_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgMinInterval: min_q    <= cfg_wdata_i;
          CfgPulseWidth:  pw_q     <= cfg_wdata_i;
          CfgDirSetup:    setup_q  <= cfg_wdata_i;
          CfgIdlePeriod:  idle_q   <= cfg_wdata_i;
          CfgMaxSpeed:    maxspd_q <= cfg_wdata_i[MagW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q  <= s_axis_tuser;
      speed_q <= s_axis_tdata[SpeedW-1:0];
    end
    res_step_q <= res_step_d;
    res_dir_q  <= res_dir_d;
    res_dly_q  <= res_dly_d;
    m_data_q   <= m_data_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks
  `SPG_ASSERT_IMP(a_pulse_needs_run, !running_q, !pulse_q,
                  "step pulse high while stopped")
  `SPG_ASSERT_IMP(a_div_done_in_div, div_rsp.done, state_q == StDiv,
                  "divider finished outside divide state")
  `SPG_ASSERT_NXT(a_target_floor, (state_q == StDiv) && div_rsp.done,
                  tgt_q >= {{(IntvW-CfgW){1'b0}}, $past(min_q)},
                  "target interval below minimum after command")

endmodule
